>>> rtl/core/logodds_pkg.sv
// ----------------------------------------------------------------------------
// logodds_pkg
// Shared constants, widths and helpers for the log-odds occupancy grid.
// ----------------------------------------------------------------------------
package logodds_pkg;

    localparam int GRID_X    = 64;
    localparam int GRID_Y    = 64;
    localparam int FRAC_BITS = 8;
    localparam int CELLS     = GRID_X * GRID_Y;
    localparam int ADDR_W    = $clog2(CELLS);

    localparam int POS_W     = 14;
    localparam int VAL_W     = 16;
    localparam int THR_W     = 8;
    localparam int SHIFT_W   = 8;
    localparam int CNT_W     = 3;
    localparam int OP_W      = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 16;

    // Cell coordinates, wide enough for any index plus one.
    localparam int CW        = 12;
    localparam int MW        = 2 * CW;
    localparam int SW        = CW + 2;

    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_UPDATE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;
    localparam logic [OP_W-1:0] OP_SHIFT  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_PRIOR     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'd1;

    localparam logic [THR_W-1:0] THR_RESET = 8'd26;

    typedef logic [CW-1:0] coord_t;
    typedef logic [ADDR_W-1:0] addr_t;

    function automatic addr_t cell_addr(input coord_t x, input coord_t y);
        logic [MW-1:0] p;
        begin
            p = {{CW{1'b0}}, y} * MW'(GRID_X) + {{CW{1'b0}}, x};
            return p[ADDR_W-1:0];
        end
    endfunction

endpackage

>>> rtl/core/logodds_cmd_if.sv
// ----------------------------------------------------------------------------
// logodds_cmd_if
// Command channel: operation code, position, measurement and shift.
// ----------------------------------------------------------------------------
interface logodds_cmd_if;
    logic                                     valid;
    logic                                     ready;
    logic [logodds_pkg::OP_W-1:0]             opcode;
    logic [logodds_pkg::POS_W-1:0]            pos_x;
    logic [logodds_pkg::POS_W-1:0]            pos_y;
    logic signed [logodds_pkg::VAL_W-1:0]     meas_log_odds;
    logic signed [logodds_pkg::SHIFT_W-1:0]   shift_x;
    logic signed [logodds_pkg::SHIFT_W-1:0]   shift_y;

    modport source (output valid, opcode, pos_x, pos_y, meas_log_odds, shift_x, shift_y,
                    input ready);
    modport sink   (input valid, opcode, pos_x, pos_y, meas_log_odds, shift_x, shift_y,
                    output ready);
endinterface

>>> rtl/core/logodds_rsp_if.sv
// ----------------------------------------------------------------------------
// logodds_rsp_if
// Response channel: cell value, status and count of cells written.
// ----------------------------------------------------------------------------
interface logodds_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [logodds_pkg::VAL_W-1:0] cell_value;
    logic                                 status;
    logic [logodds_pkg::CNT_W-1:0]        cells_written;

    modport source (output valid, cell_value, status, cells_written, input ready);
    modport sink   (input valid, cell_value, status, cells_written, output ready);
endinterface

>>> rtl/core/logodds_cfg_if.sv
// ----------------------------------------------------------------------------
// logodds_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface logodds_cfg_if;
    logic                                  valid;
    logic                                  ready;
    logic [logodds_pkg::CFG_IDX_W-1:0]     index;
    logic [logodds_pkg::CFG_DAT_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/logodds_ram.sv
// ----------------------------------------------------------------------------
// logodds_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module logodds_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> rtl/core/log_odds_occupancy_grid.sv
// ----------------------------------------------------------------------------
// log_odds_occupancy_grid
// Commands are taken one at a time. A read issues the RAM read and returns the
// data; an update takes a read step and a write step for each cell written and
// one step for each target skipped; clear and shift sweep every cell.
// Throughput is set by the single read and single write port of the cell RAM.
// Reset: a clearing pass over every cell zeroes the grid; commands
// wait for it, configuration writes are taken at once.
// ----------------------------------------------------------------------------
module log_odds_occupancy_grid (
    input  logic          clk,
    input  logic          rst_n,
    logodds_cmd_if.sink   cmd,
    logodds_rsp_if.source rsp,
    logodds_cfg_if.sink   cfg
);
    localparam logic [3:0] ST_INIT = 4'd0;
    localparam logic [3:0] ST_IDLE = 4'd1;
    localparam logic [3:0] ST_CLR  = 4'd2;
    localparam logic [3:0] ST_SHF  = 4'd3;
    localparam logic [3:0] ST_SDRN = 4'd4;
    localparam logic [3:0] ST_URD  = 4'd5;
    localparam logic [3:0] ST_UWR  = 4'd6;
    localparam logic [3:0] ST_RRD  = 4'd7;
    localparam logic [3:0] ST_FIN  = 4'd8;

    localparam int IDX_W = logodds_pkg::POS_W - logodds_pkg::FRAC_BITS;

    // Configuration registers
    logic signed [logodds_pkg::VAL_W-1:0] prior_reg;
    logic [logodds_pkg::THR_W-1:0]        thr_reg;

    // Sequencer and latched command
    logic [3:0]                 state_reg, state_next;
    logic                       bank_reg, bank_next;
    logodds_pkg::coord_t        x_reg, x_next, y_reg, y_next;
    logodds_pkg::coord_t        ix_reg, ix_next, iy_reg, iy_next;
    logic                       nx_reg, nx_next, ny_reg, ny_next;
    logic signed [logodds_pkg::VAL_W:0]     delta_reg, delta_next;
    logic signed [logodds_pkg::SHIFT_W-1:0] dx_reg, dx_next, dy_reg, dy_next;
    logic [1:0]                 tgt_reg, tgt_next;
    logodds_pkg::addr_t         uaddr_reg, uaddr_next;

    // Marks a read op so FIN picks up the RAM data.
    logic                       rd_pending_reg, rd_pending_next;

    // Shift write stage
    logic                       pw_vld_reg, pw_vld_next;
    logic                       pw_in_reg, pw_in_next;
    logodds_pkg::addr_t         pw_addr_reg, pw_addr_next;

    // Result staging and output register
    logic signed [logodds_pkg::VAL_W-1:0] val_reg, val_next;
    logic                       st_reg, st_next;
    logic [logodds_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                       ov_reg, ov_next;
    logic signed [logodds_pkg::VAL_W-1:0] oval_reg, oval_next;
    logic                       ost_reg, ost_next;
    logic [logodds_pkg::CNT_W-1:0] ocnt_reg, ocnt_next;

    // Memory ports
    logic                       wr_en, wr_other, wsel;
    logodds_pkg::addr_t         wr_addr, rd_addr;
    logic [logodds_pkg::VAL_W-1:0] wr_data, rd0, rd1, rd_data;

    // Helpers
    logic                       sweep_last;
    logodds_pkg::coord_t        x_inc, y_inc;
    logodds_pkg::coord_t        cx, cy;
    logic                       tgt_en, tgt_in;
    logic signed [logodds_pkg::SW-1:0] sx, sy;
    logic                       src_in;
    logic signed [logodds_pkg::VAL_W+1:0] sum;
    logic signed [logodds_pkg::VAL_W-1:0] sat;
    logic [logodds_pkg::FRAC_BITS-1:0] fx, fy;
    logic [IDX_W-1:0]           cmd_ix, cmd_iy;

    // Two banks: reads and in-place writes use the active bank, a shift
    // copies into the other bank and then swaps them.
    assign wsel = bank_reg ^ wr_other;

    logodds_ram #(.WIDTH(logodds_pkg::VAL_W), .DEPTH(logodds_pkg::CELLS)) u_bank0 (
        .clk   (clk),
        .we    (wr_en & ~wsel),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rd0)
    );

    logodds_ram #(.WIDTH(logodds_pkg::VAL_W), .DEPTH(logodds_pkg::CELLS)) u_bank1 (
        .clk   (clk),
        .we    (wr_en & wsel),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rd1)
    );

    assign rd_data = bank_reg ? rd1 : rd0;

    // Configuration writes are always taken.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prior_reg <= '0;
            thr_reg   <= logodds_pkg::THR_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                logodds_pkg::REG_PRIOR:     prior_reg <= cfg.data;
                logodds_pkg::REG_THRESHOLD: thr_reg   <= cfg.data[logodds_pkg::THR_W-1:0];
                default: ;
            endcase
        end
    end

    assign cmd.ready         = (state_reg == ST_IDLE);
    assign rsp.valid         = ov_reg;
    assign rsp.cell_value    = oval_reg;
    assign rsp.status        = ost_reg;
    assign rsp.cells_written = ocnt_reg;

    // Grid sweep counters
    assign sweep_last = (x_reg == logodds_pkg::CW'(logodds_pkg::GRID_X - 1))
                     && (y_reg == logodds_pkg::CW'(logodds_pkg::GRID_Y - 1));
    assign x_inc = (x_reg == logodds_pkg::CW'(logodds_pkg::GRID_X - 1)) ? '0 : x_reg + 1'b1;
    assign y_inc = (x_reg == logodds_pkg::CW'(logodds_pkg::GRID_X - 1)) ? y_reg + 1'b1 : y_reg;

    // Update target: base, +y, +x, diagonal in that order.
    assign cx     = ix_reg + logodds_pkg::CW'(tgt_reg[1]);
    assign cy     = iy_reg + logodds_pkg::CW'(tgt_reg[0]);
    assign tgt_en = (tgt_reg == 2'd0) || (tgt_reg == 2'd1 && ny_reg)
                 || (tgt_reg == 2'd2 && nx_reg) || (tgt_reg == 2'd3 && nx_reg && ny_reg);
    assign tgt_in = (cx < logodds_pkg::CW'(logodds_pkg::GRID_X))
                 && (cy < logodds_pkg::CW'(logodds_pkg::GRID_Y));

    // Shift source cell for the current destination
    assign sx = $signed({2'b00, x_reg}) - logodds_pkg::SW'(dx_reg);
    assign sy = $signed({2'b00, y_reg}) - logodds_pkg::SW'(dy_reg);
    assign src_in = (sx >= 0) && (sx < $signed(logodds_pkg::SW'(logodds_pkg::GRID_X)))
                 && (sy >= 0) && (sy < $signed(logodds_pkg::SW'(logodds_pkg::GRID_Y)));

    // Saturating add of the delta to the cell read back
    assign sum = $signed({{2{rd_data[logodds_pkg::VAL_W-1]}}, rd_data})
               + $signed({delta_reg[logodds_pkg::VAL_W], delta_reg});
    always_comb
    begin
        if (sum > $signed(18'sd32767))
        begin
            sat = 16'sh7fff;
        end
        else if (sum < $signed(-18'sd32768))
        begin
            sat = 16'sh8000;
        end
        else
        begin
            sat = sum[logodds_pkg::VAL_W-1:0];
        end
    end

    assign fx     = cmd.pos_x[logodds_pkg::FRAC_BITS-1:0];
    assign fy     = cmd.pos_y[logodds_pkg::FRAC_BITS-1:0];
    assign cmd_ix = cmd.pos_x[logodds_pkg::POS_W-1:logodds_pkg::FRAC_BITS];
    assign cmd_iy = cmd.pos_y[logodds_pkg::POS_W-1:logodds_pkg::FRAC_BITS];

    always_comb
    begin
        state_next  = state_reg;
        bank_next   = bank_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        ix_next     = ix_reg;
        iy_next     = iy_reg;
        nx_next     = nx_reg;
        ny_next     = ny_reg;
        delta_next  = delta_reg;
        dx_next     = dx_reg;
        dy_next     = dy_reg;
        tgt_next    = tgt_reg;
        uaddr_next  = uaddr_reg;
        rd_pending_next = rd_pending_reg;
        pw_vld_next = 1'b0;
        pw_in_next  = pw_in_reg;
        pw_addr_next = pw_addr_reg;
        val_next    = val_reg;
        st_next     = st_reg;
        cnt_next    = cnt_reg;
        ov_next     = ov_reg & ~rsp.ready;
        oval_next   = oval_reg;
        ost_next    = ost_reg;
        ocnt_next   = ocnt_reg;
        wr_en       = 1'b0;
        wr_other    = 1'b0;
        wr_addr     = logodds_pkg::cell_addr(x_reg, y_reg);
        wr_data     = prior_reg;
        rd_addr     = logodds_pkg::cell_addr(cx, cy);

        // Shift write stage: write the destination in the other bank.
        if (pw_vld_reg)
        begin
            wr_en    = 1'b1;
            wr_other = 1'b1;
            wr_addr  = pw_addr_reg;
            wr_data  = pw_in_reg ? rd_data : prior_reg;
        end

        unique case (state_reg)
            ST_INIT:
            begin
                // Zero the active bank after reset.
                wr_en   = 1'b1;
                wr_data = '0;
                x_next  = x_inc;
                y_next  = y_inc;
                if (sweep_last)
                begin
                    x_next     = '0;
                    y_next     = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    ix_next    = logodds_pkg::CW'(cmd_ix);
                    iy_next    = logodds_pkg::CW'(cmd_iy);
                    nx_next    = {fx, 8'b0} > {thr_reg, {logodds_pkg::FRAC_BITS{1'b0}}};
                    ny_next    = {fy, 8'b0} > {thr_reg, {logodds_pkg::FRAC_BITS{1'b0}}};
                    delta_next = $signed({cmd.meas_log_odds[logodds_pkg::VAL_W-1],
                                          cmd.meas_log_odds})
                               - $signed({prior_reg[logodds_pkg::VAL_W-1], prior_reg});
                    dx_next    = cmd.shift_x;
                    dy_next    = cmd.shift_y;
                    tgt_next   = 2'd0;
                    x_next     = '0;
                    y_next     = '0;
                    val_next   = '0;
                    st_next    = 1'b0;
                    cnt_next   = '0;
                    rd_pending_next = 1'b0;
                    unique case (cmd.opcode)
                        logodds_pkg::OP_CLEAR:  state_next = ST_CLR;
                        logodds_pkg::OP_UPDATE: state_next = ST_URD;
                        logodds_pkg::OP_READ:   state_next = ST_RRD;
                        logodds_pkg::OP_SHIFT:  state_next = ST_SHF;
                        default:                state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CLR:
            begin
                // Fill the active bank with the prior.
                wr_en  = 1'b1;
                x_next = x_inc;
                y_next = y_inc;
                if (sweep_last)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_SHF:
            begin
                // Issue the source read; the write follows next cycle.
                rd_addr      = logodds_pkg::cell_addr(sx[logodds_pkg::CW-1:0],
                                                      sy[logodds_pkg::CW-1:0]);
                pw_vld_next  = 1'b1;
                pw_in_next   = src_in;
                pw_addr_next = logodds_pkg::cell_addr(x_reg, y_reg);
                x_next       = x_inc;
                y_next       = y_inc;
                if (sweep_last)
                begin
                    state_next = ST_SDRN;
                end
            end
            ST_SDRN:
            begin
                // Last copy lands this cycle; swap the banks.
                bank_next  = ~bank_reg;
                state_next = ST_FIN;
            end
            ST_URD:
            begin
                uaddr_next = logodds_pkg::cell_addr(cx, cy);
                if (tgt_en && tgt_in)
                begin
                    state_next = ST_UWR;
                end
                else
                begin
                    if (tgt_en)
                    begin
                        st_next = 1'b1;
                    end
                    tgt_next = tgt_reg + 1'b1;
                    // Base cell off the grid, or the last target, ends the update.
                    if (tgt_reg == 2'd3 || tgt_reg == 2'd0)
                    begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_UWR:
            begin
                wr_en    = 1'b1;
                wr_addr  = uaddr_reg;
                wr_data  = sat;
                cnt_next = cnt_reg + 1'b1;
                if (tgt_reg == 2'd0)
                begin
                    val_next = sat;
                end
                tgt_next = tgt_reg + 1'b1;
                state_next = (tgt_reg == 2'd3) ? ST_FIN : ST_URD;
            end
            ST_RRD:
            begin
                // Read issued at cx/cy (tgt is zero); data arrives in FIN and
                // stays on the RAM output while FIN waits.
                state_next      = ST_FIN;
                rd_pending_next = tgt_in;
                if (!tgt_in)
                begin
                    st_next = 1'b1;
                end
            end
            ST_FIN:
            begin
                // Hold until the output register is free.
                if (!ov_reg || rsp.ready)
                begin
                    ov_next    = 1'b1;
                    oval_next  = rd_pending_reg ? rd_data : val_reg;
                    ost_next   = st_reg;
                    ocnt_next  = cnt_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_INIT;
            bank_reg       <= 1'b0;
            x_reg          <= '0;
            y_reg          <= '0;
            tgt_reg        <= '0;
            pw_vld_reg     <= 1'b0;
            ov_reg         <= 1'b0;
            rd_pending_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            bank_reg       <= bank_next;
            x_reg          <= x_next;
            y_reg          <= y_next;
            tgt_reg        <= tgt_next;
            pw_vld_reg     <= pw_vld_next;
            ov_reg         <= ov_next;
            rd_pending_reg <= rd_pending_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ix_reg      <= ix_next;
        iy_reg      <= iy_next;
        nx_reg      <= nx_next;
        ny_reg      <= ny_next;
        delta_reg   <= delta_next;
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
        uaddr_reg   <= uaddr_next;
        pw_in_reg   <= pw_in_next;
        pw_addr_reg <= pw_addr_next;
        val_reg     <= val_next;
        st_reg      <= st_next;
        cnt_reg     <= cnt_next;
        oval_reg    <= oval_next;
        ost_reg     <= ost_next;
        ocnt_reg    <= ocnt_next;
    end
endmodule
